@@ sv/pdps_pkg.sv @@
// Shared types and constants for the PLL divider plan search.
// Used by pdps_ctrl, pdps_datapath and pll_divider_plan_search.
`default_nettype none
package pdps_pkg;

	localparam int unsigned B_LIMIT        = 1000;
	localparam int unsigned B_MIN          = 3;
	localparam int unsigned CHAN_DIV_LIMIT = 32;
	localparam int unsigned VCO_DIV_MIN    = 2;
	localparam int unsigned VCO_DIV_MAX    = 6;
	localparam int unsigned PRESC_COUNT    = 8;
	localparam logic [31:0] B_CLOCK_MAX_HZ = 32'd250000000;

	localparam logic [31:0] REF_RESET      = 32'd25000000;
	localparam logic [31:0] VCO_LOW_RESET  = 32'd2550000000;
	localparam logic [31:0] VCO_HIGH_RESET = 32'd2950000000;

	// divider: 32-bit dividend, 4 quotient bits per cycle
	localparam int unsigned DIV_BITS_PER_STEP = 4;
	localparam int unsigned DIV_STEPS         = 32 / DIV_BITS_PER_STEP;

	typedef enum logic [1:0] {
		ST_EXACT   = 2'd0,
		ST_NEAREST = 2'd1,
		ST_NONE    = 2'd2
	} plan_status_t;

	typedef enum logic [1:0] {
		CFG_REF      = 2'd0,
		CFG_VCO_LOW  = 2'd1,
		CFG_VCO_HIGH = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic init;
		logic calc_n;
		logic mul;
		logic div_start;
		logic div_step;
		logic upd;
		logic inc_cd;
		logic inc_vd;
		logic inc_a;
		logic inc_b;
		logic inc_pi;
		logic load_out;
	} pdps_cmd_t;

	typedef struct packed {
		logic zero_in;
		logic skip_a;
		logic over_high;
		logic a_zero;
		logic cand_ok;
		logic div_last;
		logic o_le_target;
		logic last_cd;
		logic last_vd;
		logic last_a;
		logic last_b;
		logic last_pi;
	} pdps_stat_t;

	// {fixed-divide flag, P}
	function automatic logic [6:0] presc_entry(input logic [2:0] idx);
		logic [6:0] e;
		begin
			case (idx)
				3'd0: e = {1'b1, 6'd1};
				3'd1: e = {1'b1, 6'd2};
				3'd2: e = {1'b0, 6'd2};
				3'd3: e = {1'b0, 6'd4};
				3'd4: e = {1'b0, 6'd8};
				3'd5: e = {1'b0, 6'd16};
				3'd6: e = {1'b0, 6'd32};
				default: e = {1'b1, 6'd3};
			endcase
			return e;
		end
	endfunction

endpackage
`default_nettype wire

@@ sv/pdps_datapath.sv @@
// Datapath of the PLL divider plan search: config registers, loop counters,
// VCO multiply, 4-bit-per-cycle divider, best-plan tracking and result registers.
// Depends on pdps_pkg.
`default_nettype none
module pdps_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic [31:0]        want_hz,
	input  wire pdps_pkg::pdps_cmd_t cmd,
	output pdps_pkg::pdps_stat_t    stat,
	output logic [1:0]              status,
	output logic [4:0]              a_count,
	output logic [9:0]              b_count,
	output logic [2:0]              prescaler_index,
	output logic [5:0]              prescaler_ratio,
	output logic [2:0]              vco_div,
	output logic [5:0]              channel_div,
	output logic [31:0]             vco_freq,
	output logic [31:0]             output_freq
);
	import pdps_pkg::*;

	logic [31:0] ref_q, low_q, high_q, target_q;
	logic [2:0]  pi_q;
	logic [9:0]  b_q;
	logic [4:0]  a_q;
	logic [2:0]  vd_q;
	logic [5:0]  cd_q;
	logic [15:0] n_q;
	logic [47:0] vco_q;
	logic [31:0] centre_q;
	logic [7:0]  rem_q, dsr_q;
	logic [31:0] quo_q;
	logic [2:0]  cnt_q;
	logic        found_q;
	logic [31:0] min_err_q, best_centre_q;
	logic [4:0]  best_a_q;
	logic [9:0]  best_b_q;
	logic [2:0]  best_pi_q, best_vd_q;
	logic [5:0]  best_p_q, best_cd_q;
	logic [31:0] best_vco_q, best_out_q;

	logic [6:0]  pe;
	logic        fixed;
	logic [5:0]  p;
	logic [4:0]  amax;
	logic [32:0] band_sum;
	logic [31:0] mid, centre;
	logic [37:0] bclk_lim;
	logic [31:0] err;
	logic        take;
	logic [7:0]  r_nx;
	logic [31:0] q_nx;
	logic [8:0]  t;

	assign pe       = presc_entry(pi_q);
	assign fixed    = pe[6];
	assign p        = pe[5:0];
	assign amax     = fixed ? 5'd0 : 5'(p - 6'd1);
	assign band_sum = {1'b0, low_q} + {1'b0, high_q};
	assign mid      = band_sum[32:1];
	assign centre   = (vco_q[31:0] > mid) ? vco_q[31:0] - mid : mid - vco_q[31:0];
	assign bclk_lim = ({6'd0, B_CLOCK_MAX_HZ} + 38'd1) * {32'd0, p};
	assign err      = (quo_q > target_q) ? quo_q - target_q : target_q - quo_q;
	assign take     = !found_q || (err < min_err_q) ||
	                  (err == min_err_q && centre_q < best_centre_q);

	always_comb begin
		stat.zero_in     = (ref_q == 32'd0) || (target_q == 32'd0);
		stat.skip_a      = !fixed && ({5'd0, a_q} >= b_q);
		stat.over_high   = vco_q > {16'd0, high_q};
		stat.a_zero      = (a_q == 5'd0);
		stat.cand_ok     = (vco_q >= {16'd0, low_q}) && (vco_q <= {16'd0, high_q}) &&
		                   (vco_q < {10'd0, bclk_lim});
		stat.div_last    = (cnt_q == 3'(DIV_STEPS - 1));
		stat.o_le_target = (quo_q <= target_q);
		stat.last_cd     = (cd_q == 6'(CHAN_DIV_LIMIT));
		stat.last_vd     = (vd_q == 3'(VCO_DIV_MAX));
		stat.last_a      = (a_q == amax);
		stat.last_b      = (b_q == 10'(B_LIMIT));
		stat.last_pi     = (pi_q == 3'(PRESC_COUNT - 1));
	end

	// restoring division, several quotient bits per cycle
	always_comb begin
		r_nx = rem_q;
		q_nx = quo_q;
		t    = 9'd0;
		for (int k = 0; k < DIV_BITS_PER_STEP; k++) begin
			t    = {r_nx, q_nx[31]};
			q_nx = {q_nx[30:0], 1'b0};
			if (t >= {1'b0, dsr_q}) begin
				t       = t - {1'b0, dsr_q};
				q_nx[0] = 1'b1;
			end
			r_nx = t[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= REF_RESET;
			low_q  <= VCO_LOW_RESET;
			high_q <= VCO_HIGH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REF:      ref_q  <= cfg_data;
				CFG_VCO_LOW:  low_q  <= cfg_data;
				CFG_VCO_HIGH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.init) begin
			found_q <= 1'b0;
		end else if (cmd.upd && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			target_q <= want_hz;
			pi_q     <= 3'd0;
			b_q      <= 10'(B_MIN);
			a_q      <= 5'd0;
		end
		if (cmd.calc_n)
			n_q <= {10'd0, p} * {6'd0, b_q} + {11'd0, a_q};
		if (cmd.mul) begin
			vco_q <= ref_q * n_q;
			vd_q  <= 3'(VCO_DIV_MIN);
			cd_q  <= 6'd1;
		end
		if (cmd.inc_a)
			a_q <= a_q + 5'd1;
		if (cmd.inc_b) begin
			b_q <= b_q + 10'd1;
			a_q <= 5'd0;
		end
		if (cmd.inc_pi) begin
			pi_q <= pi_q + 3'd1;
			b_q  <= 10'(B_MIN);
			a_q  <= 5'd0;
		end
		if (cmd.inc_cd)
			cd_q <= cd_q + 6'd1;
		if (cmd.inc_vd) begin
			vd_q <= vd_q + 3'd1;
			cd_q <= 6'd1;
		end
		if (cmd.div_start) begin
			centre_q <= centre;
			quo_q    <= vco_q[31:0];
			rem_q    <= 8'd0;
			dsr_q    <= {5'd0, vd_q} * {2'd0, cd_q};
			cnt_q    <= 3'd0;
		end
		if (cmd.div_step) begin
			quo_q <= q_nx;
			rem_q <= r_nx;
			cnt_q <= cnt_q + 3'd1;
		end
		if (cmd.upd && take) begin
			min_err_q     <= err;
			best_centre_q <= centre_q;
			best_a_q      <= a_q;
			best_b_q      <= b_q;
			best_pi_q     <= pi_q;
			best_p_q      <= p;
			best_vd_q     <= vd_q;
			best_cd_q     <= cd_q;
			best_vco_q    <= vco_q[31:0];
			best_out_q    <= quo_q;
		end
		if (cmd.load_out) begin
			if (found_q && !stat.zero_in) begin
				status          <= (min_err_q == 32'd0) ? ST_EXACT : ST_NEAREST;
				a_count         <= best_a_q;
				b_count         <= best_b_q;
				prescaler_index <= best_pi_q;
				prescaler_ratio <= best_p_q;
				vco_div         <= best_vd_q;
				channel_div     <= best_cd_q;
				vco_freq        <= best_vco_q;
				output_freq     <= best_out_q;
			end else begin
				status          <= ST_NONE;
				a_count         <= 5'd0;
				b_count         <= 10'd0;
				prescaler_index <= 3'd0;
				prescaler_ratio <= 6'd0;
				vco_div         <= 3'd0;
				channel_div     <= 6'd0;
				vco_freq        <= 32'd0;
				output_freq     <= 32'd0;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/pdps_ctrl.sv @@
// Sequencer of the PLL divider plan search: walks prescaler, B, A,
// VCO divider and channel divider, and runs the item handshakes.
// Depends on pdps_pkg.
`default_nettype none
module pdps_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire pdps_pkg::pdps_stat_t stat,
	output pdps_pkg::pdps_cmd_t       cmd
);
	import pdps_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_PRE    = 12'b000000000010,
		S_NCALC  = 12'b000000000100,
		S_MUL    = 12'b000000001000,
		S_CHK    = 12'b000000010000,
		S_DIVS   = 12'b000000100000,
		S_DIVW   = 12'b000001000000,
		S_UPD    = 12'b000010000000,
		S_ADV_VD = 12'b000100000000,
		S_ADV_A  = 12'b001000000000,
		S_ADV_B  = 12'b010000000000,
		S_FIN    = 12'b100000000000
	} state_t;

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   adv_pi;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		adv_pi   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.init = 1'b1;
					state_nx = S_PRE;
				end
			end
			S_PRE: begin
				state_nx = stat.zero_in ? S_FIN : S_NCALC;
			end
			S_NCALC: begin
				if (stat.skip_a) begin
					state_nx = S_ADV_A;
				end else begin
					cmd.calc_n = 1'b1;
					state_nx   = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_CHK;
			end
			S_CHK: begin
				// at A = 0 the VCO is ref*P*B: past the band ends this prescaler
				if (stat.a_zero && stat.over_high)
					adv_pi = 1'b1;
				else if (!stat.cand_ok)
					state_nx = S_ADV_A;
				else
					state_nx = S_DIVS;
			end
			S_DIVS: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DIVW;
			end
			S_DIVW: begin
				cmd.div_step = 1'b1;
				if (stat.div_last)
					state_nx = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				// once the output is at or below target, larger dividers only lose
				if (stat.o_le_target || stat.last_cd) begin
					state_nx = S_ADV_VD;
				end else begin
					cmd.inc_cd = 1'b1;
					state_nx   = S_DIVS;
				end
			end
			S_ADV_VD: begin
				if (stat.last_vd) begin
					state_nx = S_ADV_A;
				end else begin
					cmd.inc_vd = 1'b1;
					state_nx   = S_DIVS;
				end
			end
			S_ADV_A: begin
				if (stat.last_a) begin
					state_nx = S_ADV_B;
				end else begin
					cmd.inc_a = 1'b1;
					state_nx  = S_NCALC;
				end
			end
			S_ADV_B: begin
				if (stat.last_b) begin
					adv_pi = 1'b1;
				end else begin
					cmd.inc_b = 1'b1;
					state_nx  = S_NCALC;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
		if (adv_pi) begin
			if (stat.last_pi) begin
				state_nx = S_FIN;
			end else begin
				cmd.inc_pi = 1'b1;
				state_nx   = S_NCALC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ sv/pll_divider_plan_search.sv @@
// PLL divider plan search, top level: sequencer plus datapath.
// Depends on pdps_pkg, pdps_ctrl and pdps_datapath.
`default_nettype none
// For each target frequency the block walks all eight prescaler entries,
// B from 3 upward (stopping once ref*P*B passes the VCO band top), every A,
// and for each VCO inside the band and the 250 MHz B-counter limit, VCO
// dividers 2..6 and channel dividers 1..32, keeping the first plan with the
// smallest error (ties go to the VCO nearest the band centre). One item is
// searched at a time. A/B candidates with A >= B are skipped; each in-band
// one runs every divider pair tried through one shared divider (4 quotient
// bits a cycle), with the channel divider loop cut short once the output
// falls to the target. A zero target or reference goes straight to the
// finish with no plan. A finished result sits in the output registers while
// the next item is accepted.
module pll_divider_plan_search (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] want_hz,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [4:0]       a_count,
	output logic [9:0]       b_count,
	output logic [2:0]       prescaler_index,
	output logic [5:0]       prescaler_ratio,
	output logic [2:0]       vco_div,
	output logic [5:0]       channel_div,
	output logic [31:0]      vco_freq,
	output logic [31:0]      output_freq
);
	import pdps_pkg::*;

	pdps_cmd_t  cmd;
	pdps_stat_t stat;

	pdps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pdps_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.want_hz         (want_hz),
		.cmd             (cmd),
		.stat            (stat),
		.status          (status),
		.a_count         (a_count),
		.b_count         (b_count),
		.prescaler_index (prescaler_index),
		.prescaler_ratio (prescaler_ratio),
		.vco_div         (vco_div),
		.channel_div     (channel_div),
		.vco_freq        (vco_freq),
		.output_freq     (output_freq)
	);

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Testbench for pll_divider_plan_search: random and directed frequency targets
// over several register settings, checked against an exhaustive plan search.
// Depends on pdps_pkg and the pll_divider_plan_search RTL.
`timescale 1ns / 100ps
module tb;
	import pdps_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]   status;
		logic [4:0]   a_count;
		logic [9:0]   b_count;
		logic [2:0]   prescaler_index;
		logic [5:0]   prescaler_ratio;
		logic [2:0]   vco_div;
		logic [5:0]   channel_div;
		logic [31:0]  vco_freq;
		logic [31:0]  output_freq;
	} plan_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] want_hz = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	plan_t       got;

	// register copies used by the plan search
	logic [31:0] ref_hz = REF_RESET;
	logic [31:0] band_lo = VCO_LOW_RESET;
	logic [31:0] band_hi = VCO_HIGH_RESET;

	logic [31:0] target_q[$];
	plan_t       plan_q[$];
	int          gap_cnt = 0;
	int          stall_cnt = 0;
	bit          quiet = 1'b0;
	int          errors = 0;

	always #2 clk = ~clk;

	pll_divider_plan_search i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .want_hz(want_hz),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(got.status), .a_count(got.a_count), .b_count(got.b_count),
		.prescaler_index(got.prescaler_index), .prescaler_ratio(got.prescaler_ratio),
		.vco_div(got.vco_div), .channel_div(got.channel_div),
		.vco_freq(got.vco_freq), .output_freq(got.output_freq)
	);

	// {fixed-divide, P} per prescaler index
	function automatic logic [6:0] presc_of(int idx);
		logic [6:0] tbl [8];
		tbl = '{7'h41, 7'h42, 7'h02, 7'h04, 7'h08, 7'h10, 7'h20, 7'h43};
		return tbl[idx];
	endfunction

	function automatic plan_t search_plan(logic [31:0] tgt);
		plan_t best;
		bit found, fixed;
		logic [6:0] pe;
		longint unsigned mid, min_err, best_ctr, vco, ctr, bus, o, err, p, amax;
		best = '0;
		found = 0;
		min_err = 0;
		best_ctr = 0;
		mid = (longint'(band_lo) + longint'(band_hi)) / 2;
		if (ref_hz != 0 && tgt != 0) begin
			for (int pi = 0; pi < 8; pi++) begin
				pe = presc_of(pi);
				fixed = pe[6];
				p = {58'd0, pe[5:0]};
				amax = fixed ? 0 : p - 1;
				for (longint unsigned b = 3; b <= B_LIMIT; b++) begin
					if (longint'(ref_hz) * p * b > longint'(band_hi))
						break;
					for (longint unsigned a = 0; a <= amax; a++) begin
						if (!fixed && a >= b)
							continue;
						vco = longint'(ref_hz) * (p * b + a);
						if (vco < band_lo || vco > band_hi || vco / p > B_CLOCK_MAX_HZ)
							continue;
						ctr = (vco > mid) ? vco - mid : mid - vco;
						for (int vd = 2; vd <= 6; vd++) begin
							bus = vco / vd;
							for (int cd = 1; cd <= CHAN_DIV_LIMIT; cd++) begin
								o = bus / cd;
								err = (o > tgt) ? o - tgt : longint'(tgt) - o;
								if (!found || err < min_err ||
										(err == min_err && ctr < best_ctr)) begin
									found = 1;
									min_err = err;
									best_ctr = ctr;
									best.a_count = 5'(a);
									best.b_count = 10'(b);
									best.prescaler_index = 3'(pi);
									best.prescaler_ratio = 6'(p);
									best.vco_div = 3'(vd);
									best.channel_div = 6'(cd);
									best.vco_freq = 32'(vco);
									best.output_freq = 32'(o);
								end
							end
						end
					end
				end
			end
		end
		if (!found)
			best.status = ST_NONE;
		else
			best.status = (min_err == 0) ? ST_EXACT : ST_NEAREST;
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			want_hz <= '0;
			gap_cnt <= 0;
		end else begin
			if (in_valid && in_ready)
				plan_q.push_back(search_plan(want_hz));
			if (!in_valid || in_ready) begin
				if (gap_cnt > 0) begin
					gap_cnt <= gap_cnt - 1;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 4) == 0) begin
					gap_cnt <= $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (target_q.size() > 0) begin
					in_valid <= 1'b1;
					want_hz <= target_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		plan_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cnt <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (plan_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result with no item pending", $realtime);
				end else begin
					e = plan_q.pop_front();
					check_field("status", 32'(e.status), 32'(got.status));
					check_field("a_count", 32'(e.a_count), 32'(got.a_count));
					check_field("b_count", 32'(e.b_count), 32'(got.b_count));
					check_field("prescaler_index", 32'(e.prescaler_index),
						32'(got.prescaler_index));
					check_field("prescaler_ratio", 32'(e.prescaler_ratio),
						32'(got.prescaler_ratio));
					check_field("vco_div", 32'(e.vco_div), 32'(got.vco_div));
					check_field("channel_div", 32'(e.channel_div), 32'(got.channel_div));
					check_field("vco_freq", e.vco_freq, got.vco_freq);
					check_field("output_freq", e.output_freq, got.output_freq);
				end
			end
			if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				stall_cnt <= $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_REF)
			ref_hz = val;
		else if (idx == CFG_VCO_LOW)
			band_lo = val;
		else if (idx == CFG_VCO_HIGH)
			band_hi = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sample at the falling edge so driver updates have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (target_q.size() > 0 || in_valid || plan_q.size() > 0);
		repeat (20) @(posedge clk);
	endtask

	// target built from a random multiple of the reference and random VCO and channel dividers
	function automatic logic [31:0] reachable(int n_lo, int n_hi);
		longint unsigned vco;
		vco = longint'(ref_hz) * $urandom_range(n_lo, n_hi);
		return 32'(vco / $urandom_range(2, 6) / $urandom_range(1, 32));
	endfunction

	task automatic push_random(int count, int n_lo, int n_hi);
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 2))
				0: target_q.push_back($urandom);
				1: target_q.push_back($urandom_range(13_000_000, 1_500_000_000));
				default: target_q.push_back(reachable(n_lo, n_hi));
			endcase
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// defaults: 25 MHz reference, 2.55..2.95 GHz band
		target_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1_475_000_000,
			32'd1_275_000_000, 32'd900_000_000, 32'd80_000_000, 32'd13_541_666,
			32'd12_345_678, 32'd491_666_666, 32'd100_000_000};
		push_random(35, 102, 118);
		wait_drained();

		// zero reference: every search fails
		cfg_write(CFG_REF, 32'd0);
		push_random(5, 1, 1);
		wait_drained();

		// huge reference over the full band: no plan fits
		cfg_write(CFG_REF, 32'hFFFF_FFFF);
		cfg_write(CFG_VCO_LOW, 32'd0);
		cfg_write(CFG_VCO_HIGH, 32'hFFFF_FFFF);
		target_q = '{32'd1, 32'hFFFF_FFFF, 32'd1_000_000};
		wait_drained();

		// 10 MHz reference, 1.0..1.2 GHz band; a write to an unused index is dropped
		cfg_write(CFG_REF, 32'd10_000_000);
		cfg_write(CFG_VCO_LOW, 32'd1_000_000_000);
		cfg_write(CFG_VCO_HIGH, 32'd1_200_000_000);
		cfg_write(CFG_UNUSED, $urandom);
		push_random(25, 100, 120);
		wait_drained();

		// inverted band
		cfg_write(CFG_REF, REF_RESET);
		cfg_write(CFG_VCO_LOW, 32'd3_000_000_000);
		cfg_write(CFG_VCO_HIGH, 32'd2_000_000_000);
		push_random(5, 80, 120);
		wait_drained();

		// back to defaults with both sides running flat out
		cfg_write(CFG_VCO_LOW, VCO_LOW_RESET);
		cfg_write(CFG_VCO_HIGH, VCO_HIGH_RESET);
		quiet = 1'b1;
		push_random(20, 102, 118);
		wait_drained();
		repeat (30) @(posedge clk);

		if (errors == 0 && plan_q.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#(500_000_000);
		$display("tb failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/pdps_pkg.sv
sv/pdps_datapath.sv
sv/pdps_ctrl.sv
sv/pll_divider_plan_search.sv
dv/tb.sv
